// ----- rtl/core/two_level_local_history_predictor_top_defines.svh -----
// ----------------------------------------------------------------------------
// two level local history predictor assertion macros
// checks compiled for simulation, empty bodies under synthesis
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LOCAL_HISTORY_PREDICTOR_TOP_DEFINES_SVH
`define TWO_LEVEL_LOCAL_HISTORY_PREDICTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TLLHP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tllhp: same-cycle check failed");

// next-cycle implication
`define TLLHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tllhp: next-cycle check failed");

`else

`define TLLHP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TLLHP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/tllhp_pkg.sv -----
// ----------------------------------------------------------------------------
// tllhp_pkg
// shared widths, defaults and outcome codes of the local history predictor
// ----------------------------------------------------------------------------
package tllhp_pkg;

   localparam int ADDR_W              = 64;
   localparam int COUNT_W             = 48;
   localparam int REQ_TDATA_W         = 72;   // address + taken, padded to bytes
   localparam int RSP_FIELDS_W        = 2 + 1 + 3 * COUNT_W;
   localparam int RSP_TDATA_W         = 152;
   localparam int RSP_PAD_W           = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int HISTORY_ENTRIES_DEF = 1024;
   localparam int PATTERN_ENTRIES_DEF = 32;
   localparam int MOD_STAGES          = 8;    // address reduction stages, generic depth

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OUTCOME_CORRECT    = 2'd0,
      OUTCOME_MISPREDICT = 2'd1,
      OUTCOME_COLLISION  = 2'd2
   } outcome_type;

endpackage

// ----- rtl/core/tllhp_ram.sv -----
// ----------------------------------------------------------------------------
// tllhp_ram
// simple dual port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module tllhp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/two_level_local_history_predictor_top.sv -----
// pipeline: 3 register stages (stage 1, stage 2, output register) lead to rsp_tvalid,
//   after the address reduction pipeline when HISTORY_ENTRIES is not a power of two
// throughput: one item per cycle unless stalled, set by the single read and write port of each table
// reset: synchronous; a clearing pass then zeroes both tables, one entry per cycle,
//   through max(HISTORY_ENTRIES, PATTERN_ENTRIES) entries with req_tready low
// ----------------------------------------------------------------------------
// two_level_local_history_predictor_top
// tagged local history table feeding a shared one-bit pattern table,
// scores resolved branches and keeps saturating totals
// ----------------------------------------------------------------------------
`include "two_level_local_history_predictor_top_defines.svh"

module two_level_local_history_predictor_top
   import tllhp_pkg::*;
#(
   parameter int HISTORY_ENTRIES = HISTORY_ENTRIES_DEF,
   parameter int PATTERN_ENTRIES = PATTERN_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // branch_pc[63:0], taken[64], zero pad
   // response side
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // outcome[1:0], predicted_taken[2],
                                               // correct_count[50:3], wrong_count[98:51],
                                               // collision_count[146:99], zero pad
);

   localparam int IDX_W       = $clog2(HISTORY_ENTRIES);
   localparam int HIST_W      = $clog2(PATTERN_ENTRIES);
   localparam int HTAB_W      = ADDR_W + HIST_W;           // {history, tag}
   localparam int MAX_ENTRIES = (HISTORY_ENTRIES > PATTERN_ENTRIES) ?
                                HISTORY_ENTRIES : PATTERN_ENTRIES;
   localparam int CLR_W       = $clog2(MAX_ENTRIES);
   localparam bit IDX_POW2    = (HISTORY_ENTRIES & (HISTORY_ENTRIES - 1)) == 0;

   localparam logic [CLR_W-1:0] CLR_LAST     = CLR_W'(MAX_ENTRIES - 1);
   localparam logic [CLR_W:0]   CLR_HIST_END = (CLR_W + 1)'(HISTORY_ENTRIES);
   localparam logic [CLR_W:0]   CLR_PAT_END  = (CLR_W + 1)'(PATTERN_ENTRIES);
   localparam logic [HIST_W:0]  HIST_LIMIT   = (HIST_W + 1)'(PATTERN_ENTRIES);

   // ---------------------------------------------------------------------
   // flow control: the whole pipe advances when the output register frees
   // ---------------------------------------------------------------------
   logic              pipe_en;
   logic              rsp_tvalid_ff;
   logic              clearing_ff, clearing_in;
   logic [CLR_W-1:0]  clr_idx_ff, clr_idx_in;

   assign pipe_en    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_en && !clearing_ff;

   logic [ADDR_W-1:0] req_addr;
   logic              req_taken;

   assign req_addr  = req_tdata[ADDR_W-1:0];
   assign req_taken = req_tdata[ADDR_W];

   // ---------------------------------------------------------------------
   // clearing pass after reset, one entry of each table per cycle
   // ---------------------------------------------------------------------
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CLR_LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // ---------------------------------------------------------------------
   // table index: address modulo HISTORY_ENTRIES
   // ---------------------------------------------------------------------
   logic              a_valid;
   logic [ADDR_W-1:0] a_addr;
   logic              a_taken;
   logic [IDX_W-1:0]  a_slot;

   generate
      if (IDX_POW2) begin : g_slot_mask
         // power of two depth: the low address bits are the slot
         assign a_valid = req_tvalid && !clearing_ff;
         assign a_addr  = req_addr;
         assign a_taken = req_taken;
         assign a_slot  = req_addr[IDX_W-1:0];
      end else begin : g_slot_mod
         // remainder built msb first, a byte of address bits per stage
         localparam int STEPS = ADDR_W / MOD_STAGES;
         localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(HISTORY_ENTRIES);

         logic [MOD_STAGES-1:0] mod_valid_ff;
         logic [MOD_STAGES-1:0] mod_taken_ff;
         logic [ADDR_W-1:0]     mod_addr_ff [MOD_STAGES];
         logic [IDX_W-1:0]      mod_rem_ff  [MOD_STAGES];
         logic [IDX_W-1:0]      mod_rem_in  [MOD_STAGES];

         always_comb begin
            logic [IDX_W:0]    wide;
            logic [IDX_W-1:0]  rem;
            logic [ADDR_W-1:0] src;
            for (int k = 0; k < MOD_STAGES; k++) begin
               rem = (k == 0) ? '0 : mod_rem_ff[(k == 0) ? 0 : k - 1];
               src = (k == 0) ? req_addr : mod_addr_ff[(k == 0) ? 0 : k - 1];
               for (int b = 0; b < STEPS; b++) begin
                  wide = {rem, src[ADDR_W - 1 - k * STEPS - b]};
                  if (wide >= DEPTH_C) begin
                     wide = wide - DEPTH_C;
                  end
                  rem = wide[IDX_W-1:0];
               end
               mod_rem_in[k] = rem;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mod_valid_ff <= '0;
            end else if (pipe_en) begin
               mod_valid_ff <= {mod_valid_ff[MOD_STAGES-2:0], req_tvalid && !clearing_ff};
            end
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               mod_taken_ff <= {mod_taken_ff[MOD_STAGES-2:0], req_taken};
               for (int k = 0; k < MOD_STAGES; k++) begin
                  mod_addr_ff[k] <= (k == 0) ? req_addr : mod_addr_ff[(k == 0) ? 0 : k - 1];
                  mod_rem_ff[k]  <= mod_rem_in[k];
               end
            end
         end

         assign a_valid = mod_valid_ff[MOD_STAGES-1];
         assign a_addr  = mod_addr_ff[MOD_STAGES-1];
         assign a_taken = mod_taken_ff[MOD_STAGES-1];
         assign a_slot  = mod_rem_ff[MOD_STAGES-1];
      end
   endgenerate

   // ---------------------------------------------------------------------
   // stage 1: history table data back, forward, look up the pattern bit
   // ---------------------------------------------------------------------
   logic              p1_valid_ff;
   logic [ADDR_W-1:0] p1_addr_ff;
   logic              p1_taken_ff;
   logic [IDX_W-1:0]  p1_slot_ff;

   logic              p2_valid_ff;
   logic [ADDR_W-1:0] p2_addr_ff;
   logic              p2_taken_ff;
   logic [IDX_W-1:0]  p2_slot_ff;
   logic [HIST_W-1:0] p2_hist_ff;
   logic              p2_hit_ff;

   logic [HTAB_W-1:0] htab_rdata;
   logic [HTAB_W-1:0] htab_wdata;
   logic [IDX_W-1:0]  htab_waddr;
   logic              htab_we;
   logic [HIST_W-1:0] ptab_waddr;
   logic              ptab_wdata;
   logic              ptab_we;
   logic              ptab_rdata;

   logic              fwd_hit;
   logic [ADDR_W-1:0] tag_eff;
   logic [HIST_W-1:0] hist_eff;
   logic [HIST_W-1:0] hist_next;
   logic [HIST_W:0]   hist_wide;
   logic              tag_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p1_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_addr_ff  <= a_addr;
         p1_taken_ff <= a_taken;
         p1_slot_ff  <= a_slot;
      end
   end

   // the entry written last cycle is not yet in the read data
   always_comb begin
      fwd_hit   = p2_valid_ff && (p2_slot_ff == p1_slot_ff);
      tag_eff   = fwd_hit ? p2_addr_ff : htab_rdata[ADDR_W-1:0];
      hist_eff  = fwd_hit ? p2_hist_ff : htab_rdata[HTAB_W-1:ADDR_W];
      tag_hit   = (tag_eff == p1_addr_ff);
      // shift in the outcome, keep the history below PATTERN_ENTRIES
      hist_wide = {hist_eff, p1_taken_ff};
      if (hist_wide >= HIST_LIMIT) begin
         hist_wide = hist_wide - HIST_LIMIT;
      end
      hist_next = hist_wide[HIST_W-1:0];
   end

   // write ports: clearing pass or the item leaving stage 1
   always_comb begin
      if (clearing_ff) begin
         htab_we    = ({1'b0, clr_idx_ff} < CLR_HIST_END);
         htab_waddr = clr_idx_ff[IDX_W-1:0];
         htab_wdata = '0;
         ptab_we    = ({1'b0, clr_idx_ff} < CLR_PAT_END);
         ptab_waddr = clr_idx_ff[HIST_W-1:0];
         ptab_wdata = 1'b0;
      end else begin
         htab_we    = pipe_en && p1_valid_ff;
         htab_waddr = p1_slot_ff;
         htab_wdata = {hist_next, p1_addr_ff};
         ptab_we    = pipe_en && p1_valid_ff;
         ptab_waddr = hist_eff;
         ptab_wdata = p1_taken_ff;
      end
   end

   // local history table: {history, full address tag} per slot
   tllhp_ram #(
      .WIDTH (HTAB_W),
      .DEPTH (HISTORY_ENTRIES)
   ) u_htab (
      .clock   (clock),
      .wr_en   (htab_we),
      .wr_addr (htab_waddr),
      .wr_data (htab_wdata),
      .rd_en   (pipe_en),
      .rd_addr (a_slot),
      .rd_data (htab_rdata)
   );

   // shared pattern table; read-first, so the item's own write is not seen
   tllhp_ram #(
      .WIDTH (1),
      .DEPTH (PATTERN_ENTRIES)
   ) u_ptab (
      .clock   (clock),
      .wr_en   (ptab_we),
      .wr_addr (ptab_waddr),
      .wr_data (ptab_wdata),
      .rd_en   (pipe_en),
      .rd_addr (hist_eff),
      .rd_data (ptab_rdata)
   );

   // ---------------------------------------------------------------------
   // stage 2: score the branch, update the totals
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p2_addr_ff  <= p1_addr_ff;
         p2_taken_ff <= p1_taken_ff;
         p2_slot_ff  <= p1_slot_ff;
         p2_hist_ff  <= hist_next;
         p2_hit_ff   <= tag_hit;
      end
   end

   outcome_type        outcome_c;
   outcome_type        rsp_outcome_ff;
   logic               rsp_pred_ff;
   logic [COUNT_W-1:0] correct_cnt_ff, correct_cnt_in;
   logic [COUNT_W-1:0] wrong_cnt_ff,   wrong_cnt_in;
   logic [COUNT_W-1:0] coll_cnt_ff,    coll_cnt_in;

   always_comb begin
      if (!p2_hit_ff) begin
         outcome_c = OUTCOME_COLLISION;
      end else if (ptab_rdata == p2_taken_ff) begin
         outcome_c = OUTCOME_CORRECT;
      end else begin
         outcome_c = OUTCOME_MISPREDICT;
      end

      correct_cnt_in = correct_cnt_ff;
      wrong_cnt_in   = wrong_cnt_ff;
      coll_cnt_in    = coll_cnt_ff;
      if (p2_valid_ff) begin
         case (outcome_c)
            OUTCOME_CORRECT: begin
               if (correct_cnt_ff != COUNT_MAX) correct_cnt_in = correct_cnt_ff + 1'b1;
            end
            OUTCOME_MISPREDICT: begin
               if (wrong_cnt_ff != COUNT_MAX) wrong_cnt_in = wrong_cnt_ff + 1'b1;
            end
            OUTCOME_COLLISION: begin
               if (coll_cnt_ff != COUNT_MAX) coll_cnt_in = coll_cnt_ff + 1'b1;
            end
            default: begin
               correct_cnt_in = correct_cnt_ff;
            end
         endcase
      end
   end

   // totals change only as an item enters the output register,
   // so the counters themselves carry the totals after that item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff  <= 1'b0;
         correct_cnt_ff <= '0;
         wrong_cnt_ff   <= '0;
         coll_cnt_ff    <= '0;
      end else if (pipe_en) begin
         rsp_tvalid_ff  <= p2_valid_ff;
         correct_cnt_ff <= correct_cnt_in;
         wrong_cnt_ff   <= wrong_cnt_in;
         coll_cnt_ff    <= coll_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_outcome_ff <= outcome_c;
         rsp_pred_ff    <= ptab_rdata;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, coll_cnt_ff, wrong_cnt_ff, correct_cnt_ff,
                        rsp_pred_ff, rsp_outcome_ff};

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // no item may be in flight while the tables are being cleared
   `TLLHP_ASSERT_IMPLY(a_clear_empty, clock, reset, clearing_ff, (!p1_valid_ff && !p2_valid_ff))
   // the history used for the pattern lookup always lies inside the pattern table
   `TLLHP_ASSERT_IMPLY(a_hist_range, clock, reset, p1_valid_ff, ({1'b0, hist_eff} < HIST_LIMIT))
   // a scored item always reaches the output register
   `TLLHP_ASSERT_NEXT(a_item_out, clock, reset, (p2_valid_ff && pipe_en), rsp_tvalid_ff)

endmodule

// ----- bench/two_level_local_history_predictor_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_local_history_predictor_top_tb
// drives resolved branches into the predictor, models the tagged history
// table, pattern table and saturating totals alongside, and checks every
// scored item field by field against the modelled outcome
// ----------------------------------------------------------------------------
module two_level_local_history_predictor_top_tb
   import tllhp_pkg::*;
();

   localparam int HIST_N = HISTORY_ENTRIES_DEF;
   localparam int PAT_N  = PATTERN_ENTRIES_DEF;

   // one scored branch as the block reports it
   typedef struct packed {
      outcome_type          outcome;
      logic                 predicted;
      logic [COUNT_W-1:0]   correct;
      logic [COUNT_W-1:0]   wrong;
      logic [COUNT_W-1:0]   collided;
   } branch_score_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // branch_pc[63:0], taken[64], zero pad
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // outcome[1:0], predicted_taken[2],
                                             // correct_count[50:3], wrong_count[98:51],
                                             // collision_count[146:99], zero pad

   two_level_local_history_predictor_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the predictor tables and totals
   logic [4:0]         hist_table [HIST_N];
   logic [ADDR_W-1:0]  tag_table  [HIST_N];
   logic               pattern_table [PAT_N];
   logic [COUNT_W-1:0] correct_total, wrong_total, collision_total;

   branch_score_type   pending_scores [$];
   int                 mismatch_count = 0;
   int                 items_sent = 0;
   bit                 tx_idle_on = 1'b1;
   bit                 rx_idle_on = 1'b1;
   int                 rx_stall_left = 0;

   // working set of branch addresses for the looping part of the random test
   logic [ADDR_W-1:0]  hot_branches [16];

   function automatic logic [COUNT_W-1:0] bump_total(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // scores one branch against the shadow tables and updates them
   function automatic branch_score_type score_branch(input logic [ADDR_W-1:0] addr,
                                                     input logic tk);
      branch_score_type s;
      int               slot;
      int               hist;
      slot = int'(addr % 64'(HIST_N));
      hist = int'(hist_table[slot]) % PAT_N;
      s.predicted = pattern_table[hist];
      if (tag_table[slot] != addr) begin
         s.outcome = OUTCOME_COLLISION;
         collision_total = bump_total(collision_total);
      end else if (s.predicted == tk) begin
         s.outcome = OUTCOME_CORRECT;
         correct_total = bump_total(correct_total);
      end else begin
         s.outcome = OUTCOME_MISPREDICT;
         wrong_total = bump_total(wrong_total);
      end
      tag_table[slot]     = addr;
      pattern_table[hist] = tk;
      hist_table[slot]    = 5'(((hist << 1) | int'(tk)) % PAT_N);
      s.correct  = correct_total;
      s.wrong    = wrong_total;
      s.collided = collision_total;
      return s;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch on %s at %0t: expected %0h, got %0h", field, $realtime, want, got);
      mismatch_count++;
   endtask

   // one branch onto the request side; valid stays high into the next item
   // unless a gap is wanted
   task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic tk);
      int gap;
      gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - ADDR_W - 1){1'b0}}, tk, addr};
      do @(posedge clock); while (!req_tready);
      pending_scores.push_back(score_branch(addr, tk));
      items_sent++;
   endtask

   // result side: random backpressure and the check of each item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("unexpected item", 64'd0, 64'(rsp_tdata[1:0]));
         end else begin
            branch_score_type want;
            want = pending_scores.pop_front();
            if (rsp_tdata[1:0] != want.outcome)
               report_mismatch("outcome", 64'(want.outcome), 64'(rsp_tdata[1:0]));
            if (rsp_tdata[2] != want.predicted)
               report_mismatch("predicted_taken", 64'(want.predicted), 64'(rsp_tdata[2]));
            if (rsp_tdata[50:3] != want.correct)
               report_mismatch("correct_count", 64'(want.correct), 64'(rsp_tdata[50:3]));
            if (rsp_tdata[98:51] != want.wrong)
               report_mismatch("wrong_count", 64'(want.wrong), 64'(rsp_tdata[98:51]));
            if (rsp_tdata[146:99] != want.collided)
               report_mismatch("collision_count", 64'(want.collided), 64'(rsp_tdata[146:99]));
         end
      end
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
         rx_stall_left = idle_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // address zero matches the reset tag, the all-ones address does not,
   // and a high bit alone lands on the same slot as zero
   task automatic test_reset_tags();
      send_branch(64'd0, 1'b0);
      send_branch(64'd0, 1'b1);
      send_branch(64'd0, 1'b1);
      send_branch('1, 1'b1);
      send_branch('1, 1'b0);
      send_branch(64'h8000_0000_0000_0000, 1'b1);
      send_branch(64'd0, 1'b0);
   endtask

   // both outcomes on one branch, alternating-bit addresses
   task automatic test_outcome_patterns();
      logic [ADDR_W-1:0] a;
      a = 64'hAAAA_AAAA_AAAA_AAAA;
      for (int i = 0; i < 8; i++) send_branch(a, 1'(i));
      send_branch(64'h5555_5555_5555_5555, 1'b1);
      send_branch(64'h5555_5555_5555_5555, 1'b1);
      send_branch(64'h5555_5555_5555_5555, 1'b0);
   endtask

   // branches fighting over one history slot
   task automatic test_slot_collisions();
      for (int i = 0; i < 6; i++)
         send_branch({54'(i % 2 + 1), 10'h123}, 1'(i / 2));
   endtask

   task automatic refresh_hot_branches();
      for (int i = 0; i < 16; i++) begin
         hot_branches[i] = {$urandom, $urandom};
         // a few share a slot so that aliasing keeps happening
         if (i >= 12) hot_branches[i][9:0] = hot_branches[i - 12][9:0];
      end
   endtask

   // mostly loop-shaped runs on a small set of branches, with noise
   task automatic test_random_branches();
      int                kind;
      int                trip;
      int                reps;
      logic [ADDR_W-1:0] a;
      refresh_hot_branches();
      while (items_sent < 1850) begin
         if ($urandom_range(0, 99) < 3) refresh_hot_branches();
         if ($urandom_range(0, 99) < 4) begin
            tx_idle_on = $urandom_range(0, 2) != 0;
            rx_idle_on = $urandom_range(0, 2) != 0;
         end
         a    = hot_branches[$urandom_range(0, 15)];
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // loop exit after a fixed trip count
            trip = $urandom_range(2, 6);
            reps = $urandom_range(2, 4);
            for (int r = 0; r < reps; r++)
               for (int t = 0; t < trip; t++) send_branch(a, t != trip - 1);
         end else if (kind < 7) begin
            reps = $urandom_range(3, 8);
            trip = $urandom_range(0, 1);
            for (int r = 0; r < reps; r++) send_branch(a, 1'(trip));
         end else if (kind < 9) begin
            reps = $urandom_range(2, 8);
            for (int r = 0; r < reps; r++) send_branch(a, 1'($urandom_range(0, 1)));
         end else begin
            // unrelated branch, nearly always a collision
            send_branch({$urandom, $urandom}, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < HIST_N; i++) begin
         hist_table[i] = '0;
         tag_table[i]  = '0;
      end
      for (int i = 0; i < PAT_N; i++) pattern_table[i] = 1'b0;
      correct_total   = '0;
      wrong_total     = '0;
      collision_total = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the block clears its tables first; send_branch waits for ready
      test_reset_tags();
      test_outcome_patterns();
      test_slot_collisions();
      test_random_branches();
      req_tvalid <= 1'b0;

      while (pending_scores.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
